### hw/rtl/qmix_pkg.sv
// Shared constants and register codes for the quad X motor mixer.
package qmix_pkg;

    localparam int unsigned THR_BITS    = 12;
    localparam int unsigned EFFORT_BITS = 13;
    localparam int unsigned OUT_BITS    = 12;
    localparam int unsigned IDX_BITS    = 2;

    localparam logic [IDX_BITS-1:0] REG_PWM_MIN  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_PWM_MAX  = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_THR_FULL = 2'd2;

    localparam int unsigned PWM_MIN_RESET  = 1000;
    localparam int unsigned PWM_MAX_RESET  = 2000;
    localparam int unsigned THR_FULL_RESET = 2880;

endpackage

### hw/rtl/qmix_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module qmix_div #(
    parameter int unsigned NW = 24,
    parameter int unsigned DW = 12,
    parameter int unsigned TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_qn  [NW];
    logic [DW-1:0] r_den [NW];
    logic [TW-1:0] r_tag [NW];
    logic          r_vld [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW-1:0] src_rem;
        logic [NW-1:0] src_qn;
        logic [DW-1:0] src_den;
        logic [TW-1:0] src_tag;
        logic          src_vld;
        logic [DW:0]   t;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_qn;

        if (s == 0) begin : g_first
            assign src_rem = '0;
            assign src_qn  = i_num;
            assign src_den = i_den;
            assign src_tag = i_tag;
            assign src_vld = i_valid;
        end else begin : g_next
            assign src_rem = r_rem[s-1];
            assign src_qn  = r_qn[s-1];
            assign src_den = r_den[s-1];
            assign src_tag = r_tag[s-1];
            assign src_vld = r_vld[s-1];
        end

        always_comb begin
            t     = {src_rem, src_qn[NW-1]};
            ge    = (t >= {1'b0, src_den});
            n_rem = ge ? DW'(t - {1'b0, src_den}) : t[DW-1:0];
            n_qn  = {src_qn[NW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_qn[s]  <= n_qn;
                r_den[s] <= src_den;
                r_tag[s] <= src_tag;
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_qn[NW-1];
    assign o_tag   = r_tag[NW-1];

endmodule

### hw/rtl/quad_x_motor_mixer_desaturate_core.sv
// Top level of the quad X motor mixer with desaturation.
// Usage: a command (throttle, roll, pitch and yaw efforts, stop) is one input
// transaction on i_in_valid / o_in_ready. Each command gives exactly one result
// transaction on o_out_valid / i_out_ready with the four motor powers and the
// was_scaled flag. The configuration port writes pwm_min, pwm_max and the
// throttle full scale by index; it should be written only while the block is idle.
// Throughput is one transaction per cycle while the receiver does not stall. The
// pipeline has one stage for the throttle product, POWER_BITS+12 stages
// of the throttle divider, three mixing stages, one scaling product stage,
// 2*POWER_BITS+15 stages of the four parallel scaling dividers, and the output
// register. The long dividers set the latency.
// Reset clears every valid bit and loads the default limits (1000, 2000, 2880).
// When the receiver stalls the whole pipeline holds in place, so o_in_ready
// drops only while a finished result waits and i_out_ready is low. No
// transaction is lost or repeated.
module quad_x_motor_mixer_desaturate_core #(
    parameter int unsigned POWER_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qmix_pkg::IDX_BITS-1:0]       i_cfg_index,
    input  logic [POWER_BITS-1:0]               i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [qmix_pkg::THR_BITS-1:0]       i_throttle,
    input  logic signed [qmix_pkg::EFFORT_BITS-1:0] i_roll_effort,
    input  logic signed [qmix_pkg::EFFORT_BITS-1:0] i_pitch_effort,
    input  logic signed [qmix_pkg::EFFORT_BITS-1:0] i_yaw_effort,
    input  logic                                i_stop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [qmix_pkg::OUT_BITS-1:0]       o_front_left_power,
    output logic [qmix_pkg::OUT_BITS-1:0]       o_front_right_power,
    output logic [qmix_pkg::OUT_BITS-1:0]       o_rear_left_power,
    output logic [qmix_pkg::OUT_BITS-1:0]       o_rear_right_power,
    output logic                                o_was_scaled
);

    localparam int unsigned P    = POWER_BITS;
    localparam int unsigned EB   = qmix_pkg::EFFORT_BITS;
    localparam int unsigned NW1  = qmix_pkg::THR_BITS + P;
    localparam int unsigned W    = P + 16;
    localparam int unsigned NW2  = W - 1 + P;
    localparam int unsigned TAG1 = 1 + 3 * EB + 1;
    localparam int unsigned TAG2 = 3 + 4 * W;

    // Configuration registers.
    logic [P-1:0] r_pwm_min;
    logic [P-1:0] r_pwm_max;
    logic [P-1:0] r_thr_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_min  <= P'(qmix_pkg::PWM_MIN_RESET);
            r_pwm_max  <= P'(qmix_pkg::PWM_MAX_RESET);
            r_thr_full <= P'(qmix_pkg::THR_FULL_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qmix_pkg::REG_PWM_MIN:  r_pwm_min  <= i_cfg_data;
                qmix_pkg::REG_PWM_MAX:  r_pwm_max  <= i_cfg_data;
                qmix_pkg::REG_THR_FULL: r_thr_full <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [W-1:0] lo_w;
    logic signed [W-1:0] hi_w;
    logic [P-1:0]        fs_eff;

    assign lo_w   = signed'(W'(r_pwm_min));
    assign hi_w   = signed'(W'(r_pwm_max));
    assign fs_eff = (r_thr_full == '0) ? P'(1) : r_thr_full;

    // The whole pipeline advances together unless a result waits unread.
    logic en;
    logic r_out_vld;
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: throttle times the limit span, split into sign and magnitude.
    logic signed [P:0]   diff;
    logic [P-1:0]        abs_diff;
    logic                r1_vld;
    logic [NW1-1:0]      r1_mag;
    logic                r1_neg;
    logic signed [EB-1:0] r1_roll, r1_pitch, r1_yaw;
    logic                r1_stop;

    always_comb begin
        diff     = signed'((P+1)'(r_pwm_max)) - signed'((P+1)'(r_pwm_min));
        abs_diff = diff[P] ? P'(-diff) : diff[P-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mag   <= NW1'(i_throttle) * NW1'(abs_diff);
            r1_neg   <= diff[P];
            r1_roll  <= i_roll_effort;
            r1_pitch <= i_pitch_effort;
            r1_yaw   <= i_yaw_effort;
            r1_stop  <= i_stop;
        end
    end

    logic            d1_vld;
    logic [NW1-1:0]  d1_quo;
    logic [TAG1-1:0] d1_tag;

    qmix_div #(.NW(NW1), .DW(P), .TW(TAG1)) u_thr_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_vld),
        .i_num   (r1_mag),
        .i_den   (fs_eff),
        .i_tag   ({r1_neg, r1_roll, r1_pitch, r1_yaw, r1_stop}),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_tag   (d1_tag)
    );

    // Stage 2: throttle power with the truncated signed quotient.
    logic signed [W-1:0]  q1_w;
    logic signed [W-1:0]  q1_s;
    logic                 r2_vld;
    logic signed [W-1:0]  r2_tp;
    logic signed [EB-1:0] r2_roll, r2_pitch, r2_yaw;
    logic                 r2_stop;

    always_comb begin
        q1_w = signed'(W'(d1_quo));
        q1_s = d1_tag[TAG1-1] ? -q1_w : q1_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_tp    <= lo_w + q1_s;
            r2_roll  <= signed'(d1_tag[1 + 3*EB - 1 -: EB]);
            r2_pitch <= signed'(d1_tag[1 + 2*EB - 1 -: EB]);
            r2_yaw   <= signed'(d1_tag[1 + EB - 1 -: EB]);
            r2_stop  <= d1_tag[0];
        end
    end

    // Stage 3: X-frame mix.
    logic signed [W-1:0] er, ep, ey;
    logic                r3_vld;
    logic signed [W-1:0] r3_pw [4];
    logic                r3_stop;

    always_comb begin
        er = W'(r2_roll);
        ep = W'(r2_pitch);
        ey = W'(r2_yaw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_pw[0] <= r2_tp - er - ep + ey;
            r3_pw[1] <= r2_tp + er - ep - ey;
            r3_pw[2] <= r2_tp - er + ep - ey;
            r3_pw[3] <= r2_tp + er + ep + ey;
            r3_stop  <= r2_stop;
        end
    end

    // Stage 4: largest power, plus sign and magnitude of each power.
    logic signed [W-1:0] mx01, mx23, mx_all;
    logic                r4_vld;
    logic signed [W-1:0] r4_mx;
    logic signed [W-1:0] r4_pw  [4];
    logic [W-2:0]        r4_mag [4];
    logic [3:0]          r4_neg;
    logic                r4_stop;

    always_comb begin
        mx01   = (r3_pw[1] > r3_pw[0]) ? r3_pw[1] : r3_pw[0];
        mx23   = (r3_pw[3] > r3_pw[2]) ? r3_pw[3] : r3_pw[2];
        mx_all = (mx23 > mx01) ? mx23 : mx01;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mx   <= mx_all;
            r4_stop <= r3_stop;
            for (int k = 0; k < 4; k++) begin
                r4_pw[k]  <= r3_pw[k];
                r4_neg[k] <= r3_pw[k][W-1];
                r4_mag[k] <= r3_pw[k][W-1] ? (W-1)'(-r3_pw[k]) : r3_pw[k][W-2:0];
            end
        end
    end

    // Stage 5: magnitude times pwm_max as the scaling numerators.
    logic                r5_vld;
    logic [NW2-1:0]      r5_num [4];
    logic [3:0]          r5_neg;
    logic signed [W-1:0] r5_pw [4];
    logic [W-2:0]        r5_den;
    logic                r5_scaled;
    logic                r5_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_den    <= r4_mx[W-2:0];
            r5_scaled <= (r4_mx > hi_w);
            r5_stop   <= r4_stop;
            r5_neg    <= r4_neg;
            for (int k = 0; k < 4; k++) begin
                r5_num[k] <= NW2'(r4_mag[k]) * NW2'(r_pwm_max);
                r5_pw[k]  <= r4_pw[k];
            end
        end
    end

    // Four parallel scaling dividers; the first one carries the side data.
    logic            d2_vld;
    logic [NW2-1:0]  d2_quo [4];
    logic [TAG2-1:0] d2_tag0;
    logic [3:0]      d2_neg;
    logic [2:0]      d2_vld_unused;

    qmix_div #(.NW(NW2), .DW(W-1), .TW(TAG2)) u_scale_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_vld),
        .i_num   (r5_num[0]),
        .i_den   (r5_den),
        .i_tag   ({r5_neg[0], r5_scaled, r5_stop, r5_pw[0], r5_pw[1], r5_pw[2], r5_pw[3]}),
        .o_valid (d2_vld),
        .o_quo   (d2_quo[0]),
        .o_tag   (d2_tag0)
    );

    for (genvar k = 1; k < 4; k++) begin : g_scale_div
        qmix_div #(.NW(NW2), .DW(W-1), .TW(1)) u_scale_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r5_vld),
            .i_num   (r5_num[k]),
            .i_den   (r5_den),
            .i_tag   (r5_neg[k]),
            .o_valid (d2_vld_unused[k-1]),
            .o_quo   (d2_quo[k]),
            .o_tag   (d2_neg[k])
        );
    end

    assign d2_neg[0] = d2_tag0[TAG2-1];

    // Stage 6: pick scaled or raw power, clamp, apply stop.
    logic                d2_scaled;
    logic                d2_stop;
    logic signed [W-1:0] d2_pw   [4];
    logic signed [W-1:0] q2_w    [4];
    logic signed [W-1:0] sel_pw  [4];
    logic signed [W-1:0] clamped [4];
    logic [P-1:0]        fin     [4];

    assign d2_scaled = d2_tag0[TAG2-2];
    assign d2_stop   = d2_tag0[TAG2-3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            d2_pw[k]  = signed'(d2_tag0[(4-k)*W-1 -: W]);
            q2_w[k]   = signed'(W'(d2_quo[k][W-2:0]));
            sel_pw[k] = d2_scaled ? (d2_neg[k] ? -q2_w[k] : q2_w[k]) : d2_pw[k];
            clamped[k] = (sel_pw[k] > hi_w) ? hi_w : sel_pw[k];
            if (clamped[k] < lo_w) begin
                clamped[k] = lo_w;
            end
            fin[k] = d2_stop ? r_pwm_min : clamped[k][P-1:0];
        end
    end

    logic [P-1:0] r_pwr [4];
    logic         r_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_pwr[k] <= fin[k];
            end
            r_scaled <= d2_scaled && !d2_stop;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_front_left_power  = qmix_pkg::OUT_BITS'(r_pwr[0]);
    assign o_front_right_power = qmix_pkg::OUT_BITS'(r_pwr[1]);
    assign o_rear_left_power   = qmix_pkg::OUT_BITS'(r_pwr[2]);
    assign o_rear_right_power  = qmix_pkg::OUT_BITS'(r_pwr[3]);
    assign o_was_scaled        = r_scaled;

    // Every delivered power respects the lower limit.
    a_lower_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_pwr[0] >= r_pwm_min && r_pwr[1] >= r_pwm_min &&
                       r_pwr[2] >= r_pwm_min && r_pwr[3] >= r_pwm_min))
        else $error("motor power below pwm_min");

    // With ordered limits, every delivered power respects the upper limit.
    a_upper_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_pwm_min <= r_pwm_max) |->
            (r_pwr[0] <= r_pwm_max && r_pwr[1] <= r_pwm_max &&
             r_pwr[2] <= r_pwm_max && r_pwr[3] <= r_pwm_max))
        else $error("motor power above pwm_max");

    // A stalled result holds its valid bit, its scaled flag and the first and last powers.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=>
            (r_out_vld && $stable(r_scaled) && $stable(r_pwr[0]) &&
             $stable(r_pwr[3])))
        else $error("result changed while stalled");

    // The second and fourth scaling dividers stay in step with the first one.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d2_vld == d2_vld_unused[0]) && (d2_vld == d2_vld_unused[2]))
        else $error("scaling dividers out of step");

endmodule

### dv/tb.sv
// Self-checking testbench for the quad X motor mixer with desaturation.
`timescale 1ns / 1ps

module tb;

    localparam int PB = 12;
    localparam int LATENCY = 3 * PB + 33;
    localparam int TB_THR = qmix_pkg::THR_BITS;
    localparam int TB_EFF = qmix_pkg::EFFORT_BITS;
    localparam int TB_OUT = qmix_pkg::OUT_BITS;

    typedef struct packed {
        logic [TB_THR-1:0] throttle;
        logic [TB_EFF-1:0] roll;
        logic [TB_EFF-1:0] pitch;
        logic [TB_EFF-1:0] yaw;
        logic              stop;
    } t_command;

    typedef struct packed {
        logic [TB_OUT-1:0] fl;
        logic [TB_OUT-1:0] fr;
        logic [TB_OUT-1:0] rl;
        logic [TB_OUT-1:0] rr;
        logic              scaled;
    } t_powers;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [qmix_pkg::IDX_BITS-1:0] i_cfg_index = '0;
    logic [PB-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [TB_THR-1:0] i_throttle = '0;
    logic signed [TB_EFF-1:0] i_roll_effort = '0;
    logic signed [TB_EFF-1:0] i_pitch_effort = '0;
    logic signed [TB_EFF-1:0] i_yaw_effort = '0;
    logic i_stop = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [TB_OUT-1:0] o_front_left_power, o_front_right_power;
    logic [TB_OUT-1:0] o_rear_left_power, o_rear_right_power;
    logic o_was_scaled;

    quad_x_motor_mixer_desaturate_core #(.POWER_BITS(PB)) uut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow copy of the limits, updated when the testbench writes a register.
    longint lim_lo = qmix_pkg::PWM_MIN_RESET;
    longint lim_hi = qmix_pkg::PWM_MAX_RESET;
    longint full_scale = qmix_pkg::THR_FULL_RESET;

    t_command pending_cmds[$];
    t_powers  expected_powers[$];
    int mismatches = 0;
    bit stall_long = 0;   // receiver holds off while set
    bit feed_hold = 0;    // sender pauses while set

    function automatic longint clamp_to_limits(longint v);
        if (v > lim_hi) v = lim_hi;
        if (v < lim_lo) v = lim_lo;
        return v;
    endfunction

    // Computes the motor powers that one command should produce.
    function automatic t_powers mix_powers(t_command c);
        t_powers res;
        longint fs, tp, mx, r, p, y;
        longint pw[4];
        fs = (full_scale == 0) ? 1 : full_scale;
        if (c.stop) begin
            res.fl = TB_OUT'(lim_lo); res.fr = TB_OUT'(lim_lo);
            res.rl = TB_OUT'(lim_lo); res.rr = TB_OUT'(lim_lo);
            res.scaled = 1'b0;
            return res;
        end
        r = longint'($signed(c.roll));
        p = longint'($signed(c.pitch));
        y = longint'($signed(c.yaw));
        // SystemVerilog integer division truncates toward zero, as required.
        tp = lim_lo + (longint'(c.throttle) * (lim_hi - lim_lo)) / fs;
        pw[0] = tp - r - p + y;
        pw[1] = tp + r - p - y;
        pw[2] = tp - r + p - y;
        pw[3] = tp + r + p + y;
        mx = pw[0];
        for (int i = 1; i < 4; i++) if (pw[i] > mx) mx = pw[i];
        res.scaled = (mx > lim_hi);
        if (res.scaled) for (int i = 0; i < 4; i++) pw[i] = (pw[i] * lim_hi) / mx;
        res.fl = TB_OUT'(clamp_to_limits(pw[0]));
        res.fr = TB_OUT'(clamp_to_limits(pw[1]));
        res.rl = TB_OUT'(clamp_to_limits(pw[2]));
        res.rr = TB_OUT'(clamp_to_limits(pw[3]));
        return res;
    endfunction

    // Driver: one transaction per queued command, with a random gap after each accepted one.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            expected_powers.push_back(mix_powers(pending_cmds.pop_front()));
            send_gap = $urandom_range(0, 4);
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_ready) begin
            // Hold the offered command until it is taken.
        end else if (feed_hold) begin
            i_in_valid <= 1'b0;
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
            i_in_valid <= 1'b1;
            i_throttle <= pending_cmds[0].throttle;
            i_roll_effort <= pending_cmds[0].roll;
            i_pitch_effort <= pending_cmds[0].pitch;
            i_yaw_effort <= pending_cmds[0].yaw;
            i_stop <= pending_cmds[0].stop;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Monitor: checks each result transaction and draws the next ready gap.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            t_powers got, want;
            got = '{o_front_left_power, o_front_right_power, o_rear_left_power,
                    o_rear_right_power, o_was_scaled};
            if (expected_powers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_powers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
            recv_gap = $urandom_range(0, 4);
        end
        if (!i_rst_n || stall_long) begin
            i_out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic queue_cmd(int thr, int r, int p, int y, bit s);
        t_command c;
        c.throttle = thr[TB_THR-1:0]; c.roll = r[TB_EFF-1:0];
        c.pitch = p[TB_EFF-1:0]; c.yaw = y[TB_EFF-1:0]; c.stop = s;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(int count);
        repeat (count) begin
            int mag;
            // Mostly modest efforts around hover, sometimes anything at all.
            mag = ($urandom_range(0, 3) == 0) ? 4095 : 600;
            queue_cmd($urandom_range(0, 4095),
                      $urandom_range(0, 2 * mag) - mag,
                      $urandom_range(0, 2 * mag) - mag,
                      $urandom_range(0, 2 * mag) - mag,
                      $urandom_range(0, 15) == 0);
        end
        // Raw bit patterns make sure every input bit toggles.
        repeat (count / 10)
            queue_cmd($urandom, $urandom, $urandom, $urandom, 1'($urandom));
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && !i_in_valid && expected_powers.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle; shadow values follow.
    task automatic write_limits(int lo, int hi, int fs);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= qmix_pkg::REG_PWM_MIN; i_cfg_data <= lo[PB-1:0];
        @(posedge i_clk);
        i_cfg_index <= qmix_pkg::REG_PWM_MAX; i_cfg_data <= hi[PB-1:0];
        @(posedge i_clk);
        i_cfg_index <= qmix_pkg::REG_THR_FULL; i_cfg_data <= fs[PB-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lim_lo = lo; lim_hi = hi; full_scale = fs;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands at the reset limits: field extremes, stop, hover,
        // heavy saturation and throttle beyond full scale.
        queue_cmd(0, 0, 0, 0, 0);
        queue_cmd(2880, 0, 0, 0, 0);
        queue_cmd(4095, 0, 0, 0, 0);
        queue_cmd(1440, 4095, 0, 0, 0);
        queue_cmd(1440, -4096, 0, 0, 0);
        queue_cmd(1440, 0, 4095, 0, 0);
        queue_cmd(1440, 0, 0, -4096, 0);
        queue_cmd(4095, 4095, 4095, 4095, 0);
        queue_cmd(4095, -4096, -4096, -4096, 0);
        queue_cmd(0, -4096, -4096, -4096, 0);
        queue_cmd(4095, 4095, 4095, 4095, 1);
        queue_cmd(2000, 100, -50, 25, 0);
        drain();

        // Zero full scale and zero pwm_max.
        write_limits(0, 0, 0);
        queue_cmd(100, 10, 20, 30, 0);
        queue_cmd(0, -5, 0, 0, 0);
        queue_cmd(4095, 4095, 4095, 4095, 0);
        drain();

        // Inverted limits: pwm_min must win.
        write_limits(3000, 1000, 4095);
        queue_cmd(2000, 300, -200, 100, 0);
        queue_cmd(4095, 4095, 0, 0, 0);
        queue_cmd(0, 0, 0, 0, 1);
        drain();

        // Random phases across several settings, extremes included.
        write_limits(1000, 2000, 2880);
        queue_random(350);
        drain();
        write_limits(0, 4095, 1);
        queue_random(250);
        drain();
        write_limits(4095, 4095, 4095);
        queue_random(100);
        drain();
        write_limits($urandom_range(0, 2000), $urandom_range(1500, 4095),
                     $urandom_range(1, 4095));
        queue_random(300);
        // Long receiver stall while commands keep coming, to back up the pipe.
        wait (expected_powers.size() > 5);
        stall_long = 1;
        repeat (300) @(posedge i_clk);
        stall_long = 0;
        // Sender pauses until every outstanding result has come back.
        feed_hold = 1;
        wait (expected_powers.size() == 0);
        feed_hold = 0;
        drain();
        write_limits(1000, 2000, 2880);
        queue_random(300);
        drain();

        if (mismatches == 0 && expected_powers.size() == 0)
            $display("quad_x_motor_mixer_desaturate_core test passed");
        else
            $display("quad_x_motor_mixer_desaturate_core test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("quad_x_motor_mixer_desaturate_core test failed");
        $finish;
    end
endmodule
